>>> src/fdd_pkg.sv
`default_nettype none

package fdd_pkg;

	localparam int ACCEL_W     = 26;
	localparam int CONFIRM_W   = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 26;
	localparam int FALL_W      = 2;
	localparam int RUN_COUNT   = 5;

	typedef logic signed [ACCEL_W-1:0] accel_t;
	typedef logic [FALL_W-1:0]         fall_t;
	typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;

	// register map
	localparam cfg_index_t REG_BACK_THRESHOLD  = 3'd0;
	localparam cfg_index_t REG_FRONT_THRESHOLD = 3'd1;
	localparam cfg_index_t REG_RIGHT_THRESHOLD = 3'd2;
	localparam cfg_index_t REG_LEFT_THRESHOLD  = 3'd3;
	localparam cfg_index_t REG_REAR_THRESHOLD  = 3'd4;
	localparam cfg_index_t REG_UPRIGHT_Z_LIMIT = 3'd5;
	localparam cfg_index_t REG_CONFIRM_COUNT   = 3'd6;

	localparam accel_t RST_BACK_THRESHOLD  = 26'sd8600000;
	localparam accel_t RST_FRONT_THRESHOLD = 26'sd8600000;
	localparam accel_t RST_RIGHT_THRESHOLD = 26'sd9000000;
	localparam accel_t RST_LEFT_THRESHOLD  = -26'sd8600000;
	localparam accel_t RST_REAR_THRESHOLD  = -26'sd8500000;
	localparam accel_t RST_UPRIGHT_Z_LIMIT = -26'sd6500000;
	localparam logic [CONFIRM_W-1:0] RST_CONFIRM_COUNT = 8'd5;

	// result codes
	localparam fall_t FALL_NONE  = 2'd0;
	localparam fall_t FALL_SIDE  = 2'd1;
	localparam fall_t FALL_REAR  = 2'd2;
	localparam fall_t FALL_FRONT = 2'd3;

	// run counter slots
	localparam int SLOT_BACK  = 0;
	localparam int SLOT_REAR  = 1;
	localparam int SLOT_FRONT = 2;
	localparam int SLOT_LEFT  = 3;
	localparam int SLOT_RIGHT = 4;

	typedef enum logic [2:0] {
		DIR_NONE,
		DIR_BACK,
		DIR_REAR,
		DIR_FRONT,
		DIR_LEFT,
		DIR_RIGHT
	} dir_t;

	typedef struct packed {
		accel_t                 back_threshold;
		accel_t                 front_threshold;
		accel_t                 right_threshold;
		accel_t                 left_threshold;
		accel_t                 rear_threshold;
		accel_t                 upright_z_limit;
		logic [CONFIRM_W-1:0]   confirm_count;
	} cfg_t;

endpackage

`default_nettype wire

>>> src/fdd_if.sv
`default_nettype none

interface fdd_sample_if import fdd_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   command;
	accel_t accel_z;
	accel_t accel_forward;
	accel_t accel_side;

	modport source (output valid, output command, output accel_z, output accel_forward,
		output accel_side, input ready);
	modport sink (input valid, input command, input accel_z, input accel_forward,
		input accel_side, output ready);
endinterface

interface fdd_result_if import fdd_pkg::*; ();
	logic  valid;
	logic  ready;
	fall_t fall_state;

	modport source (output valid, output fall_state, input ready);
	modport sink (input valid, input fall_state, output ready);
endinterface

`default_nettype wire

>>> src/fdd_cfg_regs.sv
`default_nettype none

module fdd_cfg_regs import fdd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.back_threshold  <= RST_BACK_THRESHOLD;
			cfg_q.front_threshold <= RST_FRONT_THRESHOLD;
			cfg_q.right_threshold <= RST_RIGHT_THRESHOLD;
			cfg_q.left_threshold  <= RST_LEFT_THRESHOLD;
			cfg_q.rear_threshold  <= RST_REAR_THRESHOLD;
			cfg_q.upright_z_limit <= RST_UPRIGHT_Z_LIMIT;
			cfg_q.confirm_count   <= RST_CONFIRM_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BACK_THRESHOLD:  cfg_q.back_threshold  <= accel_t'(cfg_data);
				REG_FRONT_THRESHOLD: cfg_q.front_threshold <= accel_t'(cfg_data);
				REG_RIGHT_THRESHOLD: cfg_q.right_threshold <= accel_t'(cfg_data);
				REG_LEFT_THRESHOLD:  cfg_q.left_threshold  <= accel_t'(cfg_data);
				REG_REAR_THRESHOLD:  cfg_q.rear_threshold  <= accel_t'(cfg_data);
				REG_UPRIGHT_Z_LIMIT: cfg_q.upright_z_limit <= accel_t'(cfg_data);
				REG_CONFIRM_COUNT:   cfg_q.confirm_count   <= cfg_data[CONFIRM_W-1:0];
				default: ;  // unmapped index
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> src/fdd_classify.sv
`default_nettype none

module fdd_classify import fdd_pkg::*; (
	input  wire cfg_t   cfg,
	input  wire accel_t accel_z,
	input  wire accel_t accel_forward,
	input  wire accel_t accel_side,
	output dir_t        dir
);

	logic [ACCEL_W-1:0] mag_f;
	logic [ACCEL_W-1:0] mag_s;

	// two's complement magnitude; the most negative value maps to 2^25 unsigned
	assign mag_f = accel_forward[ACCEL_W-1] ? (~accel_forward + 1'b1) : accel_forward;
	assign mag_s = accel_side[ACCEL_W-1]    ? (~accel_side + 1'b1)    : accel_side;

	always_comb begin
		dir = DIR_NONE;
		if (accel_z > cfg.back_threshold) begin
			dir = DIR_BACK;
		end else if (accel_z > accel_t'(0)) begin
			// upside down: larger horizontal magnitude picks the axis
			if (mag_f > mag_s) begin
				dir = accel_forward[ACCEL_W-1] ? DIR_REAR : DIR_FRONT;
			end else begin
				dir = accel_side[ACCEL_W-1] ? DIR_LEFT : DIR_RIGHT;
			end
		end else if (accel_z > cfg.upright_z_limit) begin
			if (accel_forward < cfg.rear_threshold) begin
				dir = DIR_REAR;
			end else if (accel_side > cfg.right_threshold) begin
				dir = DIR_RIGHT;
			end else if (accel_side < cfg.left_threshold) begin
				dir = DIR_LEFT;
			end else if (accel_forward > cfg.front_threshold) begin
				dir = DIR_FRONT;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/fdd_runs.sv
`default_nettype none

module fdd_runs import fdd_pkg::*; #(
	parameter int RUN_WIDTH = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 update,
	input  wire dir_t                 dir,
	input  wire logic [CONFIRM_W-1:0] confirm_count,
	output fall_t                     fall_next,
	output logic [RUN_COUNT-1:0]      run_nz
);

	localparam int CMP_W = (RUN_WIDTH > CONFIRM_W) ? RUN_WIDTH : CONFIRM_W;

	logic [RUN_WIDTH-1:0] run_q    [RUN_COUNT];
	logic [RUN_WIDTH-1:0] run_next [RUN_COUNT];
	logic [RUN_COUNT-1:0] hit;
	logic [RUN_COUNT-1:0] over;

	always_comb begin
		hit = '0;
		hit[SLOT_BACK]  = (dir == DIR_BACK);
		hit[SLOT_REAR]  = (dir == DIR_REAR);
		hit[SLOT_FRONT] = (dir == DIR_FRONT);
		hit[SLOT_LEFT]  = (dir == DIR_LEFT);
		hit[SLOT_RIGHT] = (dir == DIR_RIGHT);
	end

	// active counter counts up and saturates, every other one clears
	always_comb begin
		for (int i = 0; i < RUN_COUNT; i++) begin
			if (!hit[i]) begin
				run_next[i] = '0;
			end else if (run_q[i] == '1) begin
				run_next[i] = run_q[i];
			end else begin
				run_next[i] = run_q[i] + 1'b1;
			end
			over[i]   = CMP_W'(run_next[i]) > CMP_W'(confirm_count);
			run_nz[i] = (run_q[i] != '0);
		end
	end

	always_comb begin
		if (over[SLOT_BACK] || over[SLOT_LEFT] || over[SLOT_RIGHT]) begin
			fall_next = FALL_SIDE;
		end else if (over[SLOT_REAR]) begin
			fall_next = FALL_REAR;
		end else if (over[SLOT_FRONT]) begin
			fall_next = FALL_FRONT;
		end else begin
			fall_next = FALL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RUN_COUNT; i++) begin
				run_q[i] <= '0;
			end
		end else if (update) begin
			for (int i = 0; i < RUN_COUNT; i++) begin
				run_q[i] <= run_next[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> src/fall_direction_detector.sv
`default_nettype none

// Fall direction detector. Each transfer on the sample channel carries one
// three-axis accelerometer frame (command = 0) or a clear request (command = 1),
// and produces exactly one transfer on the result channel with fall_state:
// 0 not fallen, 1 fallen on a side or the back, 2 fallen to the rear, 3 fallen
// to the front. A frame is sorted into a tilt direction against the threshold
// registers; the run counter of that direction counts up (saturating at
// 2^RUN_WIDTH - 1) and all other run counters clear. A fall is reported once a
// run exceeds confirm_count. A clear request, or a frame with no direction,
// clears every run and reports 0.
// Throughput is one frame per clock while results are taken. The frame is
// captured in the input register, then classification and the run counter
// update are combinational into the result register. The run counters are
// updated at the same edge the result is registered, so consecutive frames
// see each other's effect without bubbles. Both stages stall together when
// the result is not taken; the sample side keeps accepting as long as the
// result register drains or is empty.
// Configuration: cfg_we writes register cfg_index (0 back_threshold,
// 1 front_threshold, 2 right_threshold, 3 left_threshold, 4 rear_threshold,
// 5 upright_z_limit, 6 confirm_count); index 7 is ignored. Write only while
// no frame is in flight.

module fall_direction_detector import fdd_pkg::*; #(
	parameter int RUN_WIDTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fdd_sample_if.sink                 sample,
	fdd_result_if.source               result,
	input  wire logic                  cfg_we,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                 cfg;
	logic                 valid_s1;
	logic                 command_s1;
	accel_t               accel_z_s1;
	accel_t               accel_forward_s1;
	accel_t               accel_side_s1;
	logic                 out_valid_q;
	fall_t                fall_state_q;
	logic                 advance;
	logic                 update;
	dir_t                 dir;
	dir_t                 dir_eff;
	fall_t                fall_next;
	logic [RUN_COUNT-1:0] run_nz;

	fdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register empty or being taken: stage 1 may move on
	assign advance      = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;
	assign update       = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			command_s1       <= sample.command;
			accel_z_s1       <= sample.accel_z;
			accel_forward_s1 <= sample.accel_forward;
			accel_side_s1    <= sample.accel_side;
		end
	end

	fdd_classify u_classify (
		.cfg           (cfg),
		.accel_z       (accel_z_s1),
		.accel_forward (accel_forward_s1),
		.accel_side    (accel_side_s1),
		.dir           (dir)
	);

	// clear request behaves as a frame with no direction
	assign dir_eff = command_s1 ? DIR_NONE : dir;

	fdd_runs #(
		.RUN_WIDTH (RUN_WIDTH)
	) u_runs (
		.clk           (clk),
		.arst_n        (arst_n),
		.update        (update),
		.dir           (dir_eff),
		.confirm_count (cfg.confirm_count),
		.fall_next     (fall_next),
		.run_nz        (run_nz)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			fall_state_q <= fall_next;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.fall_state = fall_state_q;

	// at most one direction has a live run
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(run_nz))
		else $error("more than one run counter active");

	// a clear request always reports not fallen
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		update && command_s1 |=> result.fall_state == FALL_NONE && run_nz == '0)
		else $error("clear request did not clear fall state");

	// runs only move when a frame passes into the result register
	a_runs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> $stable(run_nz))
		else $error("run counters changed without a frame");

	// a stalled result with a frame waiting blocks the sample side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready && valid_s1 |-> !sample.ready)
		else $error("sample accepted while pipeline is full");

endmodule

`default_nettype wire

>>> tb/sv/fall_direction_detector_tb.sv
`timescale 1ns / 1ps

// Testbench for the fall direction detector.
// A directed table covers the field extremes, every tilt direction, threshold
// boundaries and clear requests; a long random part follows, made mostly of
// repeated frames so the run counters actually climb past the confirm count.
// Every accepted frame is run through a local predictor and the expected
// fall_state is queued; each result transfer is checked against the head.
module fall_direction_detector_tb;
	import fdd_pkg::*;

	localparam int RUN_W       = 8;
	localparam int RUN_MAX     = (1 << RUN_W) - 1;
	localparam int QUIET_LIMIT = 4000;  // cycles with no transfer on either side
	localparam int HOLD_CYCLES = 300;   // long result-side hold-off
	localparam int PHASE_ITEMS = 195;
	localparam int SAT_RUN     = 262;   // long enough to hit counter saturation

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;
	localparam logic TYPED      = 1'b1;
	localparam logic PREDICTED  = 1'b0;

	localparam cfg_index_t REG_UNUSED = 3'd7;

	localparam accel_t ACC_MAX = {1'b0, {(ACCEL_W-1){1'b1}}};
	localparam accel_t ACC_MIN = {1'b1, {(ACCEL_W-1){1'b0}}};

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic   cmd;
		accel_t z;
		accel_t f;
		accel_t s;
		logic   typed;
		fall_t  want;
	} frame_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fdd_sample_if sample_ch ();
	fdd_result_if result_ch ();

	fall_direction_detector #(.RUN_WIDTH(RUN_W)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: register shadow and the five run lengths
	cfg_t             cfg_shadow;
	logic [RUN_W-1:0] run_len [RUN_COUNT];

	fall_t      expected_falls [$];
	int         frames_sent;
	int         mismatches;
	int         quiet_cycles;
	idle_mode_t idle_mode;
	bit         hold_req;
	int         hold_left;

	// Directed frames, walked in order under the reset configuration
	// (confirm count 5). Only the obvious results are typed in; the rest come
	// from the predictor.
	frame_row_t directed_rows [25] = '{
		// clear requests at both field extremes
		'{CMD_CLEAR,  ACC_MAX, ACC_MAX, ACC_MAX, TYPED, FALL_NONE},
		'{CMD_CLEAR,  ACC_MIN, ACC_MIN, ACC_MIN, TYPED, FALL_NONE},
		// six frames on the back: confirmed once the run passes five
		'{CMD_SAMPLE, ACC_MAX, '0, '0, TYPED, FALL_NONE},
		'{CMD_SAMPLE, ACC_MAX, '0, '0, TYPED, FALL_NONE},
		'{CMD_SAMPLE, ACC_MAX, '0, '0, TYPED, FALL_NONE},
		'{CMD_SAMPLE, ACC_MAX, '0, '0, TYPED, FALL_NONE},
		'{CMD_SAMPLE, ACC_MAX, '0, '0, TYPED, FALL_NONE},
		'{CMD_SAMPLE, ACC_MAX, '0, '0, TYPED, FALL_SIDE},
		'{CMD_SAMPLE, ACC_MAX, ACC_MIN, ACC_MIN, PREDICTED, FALL_NONE},
		'{CMD_CLEAR,  '0, '0, '0, TYPED, FALL_NONE},
		// upside down: larger of forward and side decides
		'{CMD_SAMPLE, 26'sd1, -26'sd20000000, 26'sd10000000, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, 26'sd1, 26'sd20000000, -26'sd3, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, 26'sd1, '0, -26'sd5, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, 26'sd1, '0, '0, PREDICTED, FALL_NONE},
		// z sitting exactly on the back threshold, tied magnitudes
		'{CMD_SAMPLE, 26'sd8600000, ACC_MAX, ACC_MAX, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, 26'sd1, ACC_MIN, ACC_MAX, PREDICTED, FALL_NONE},
		// tilted band: each threshold just crossed, and one just missed
		'{CMD_SAMPLE, -26'sd1000000, -26'sd8500001, '0, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, -26'sd1000000, -26'sd8500000, '0, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, -26'sd1000000, '0, 26'sd9000001, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, -26'sd1000000, '0, -26'sd8600001, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, -26'sd1000000, 26'sd8600001, '0, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, '0, ACC_MIN, ACC_MIN, PREDICTED, FALL_NONE},
		// upright limit is inclusive
		'{CMD_SAMPLE, -26'sd6500000, ACC_MIN, ACC_MAX, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, -26'sd6499999, ACC_MAX, '0, PREDICTED, FALL_NONE},
		'{CMD_SAMPLE, ACC_MIN, ACC_MIN, ACC_MIN, TYPED, FALL_NONE}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint wide(accel_t v);
		return v;
	endfunction

	function automatic logic [RUN_W-1:0] run_step(logic [RUN_W-1:0] r);
		return (r == RUN_MAX) ? r : r + 1'b1;
	endfunction

	// Classify one frame, update the run lengths and return the fall state.
	function automatic fall_t predict_fall(logic cmd, accel_t z, accel_t f, accel_t s);
		dir_t             heading;
		longint           fmag;
		longint           smag;
		logic [RUN_W-1:0] prior [RUN_COUNT];
		prior = run_len;
		foreach (run_len[i])
			run_len[i] = '0;
		if (cmd == CMD_CLEAR)
			return FALL_NONE;

		heading = DIR_NONE;
		if (wide(z) > wide(cfg_shadow.back_threshold)) begin
			heading = DIR_BACK;
		end else if (wide(z) > 0) begin
			// upside down
			fmag = (wide(f) < 0) ? -wide(f) : wide(f);
			smag = (wide(s) < 0) ? -wide(s) : wide(s);
			if (fmag > smag)
				heading = (wide(f) < 0) ? DIR_REAR : DIR_FRONT;
			else
				heading = (wide(s) < 0) ? DIR_LEFT : DIR_RIGHT;
		end else if (wide(z) > wide(cfg_shadow.upright_z_limit)) begin
			// tilted band: first threshold that trips wins
			if (wide(f) < wide(cfg_shadow.rear_threshold))
				heading = DIR_REAR;
			else if (wide(s) > wide(cfg_shadow.right_threshold))
				heading = DIR_RIGHT;
			else if (wide(s) < wide(cfg_shadow.left_threshold))
				heading = DIR_LEFT;
			else if (wide(f) > wide(cfg_shadow.front_threshold))
				heading = DIR_FRONT;
		end

		case (heading)
			DIR_BACK:  run_len[SLOT_BACK]  = run_step(prior[SLOT_BACK]);
			DIR_REAR:  run_len[SLOT_REAR]  = run_step(prior[SLOT_REAR]);
			DIR_FRONT: run_len[SLOT_FRONT] = run_step(prior[SLOT_FRONT]);
			DIR_LEFT:  run_len[SLOT_LEFT]  = run_step(prior[SLOT_LEFT]);
			DIR_RIGHT: run_len[SLOT_RIGHT] = run_step(prior[SLOT_RIGHT]);
			default: ;
		endcase

		if (run_len[SLOT_BACK] > cfg_shadow.confirm_count
				|| run_len[SLOT_LEFT] > cfg_shadow.confirm_count
				|| run_len[SLOT_RIGHT] > cfg_shadow.confirm_count)
			return FALL_SIDE;
		if (run_len[SLOT_REAR] > cfg_shadow.confirm_count)
			return FALL_REAR;
		if (run_len[SLOT_FRONT] > cfg_shadow.confirm_count)
			return FALL_FRONT;
		return FALL_NONE;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t: MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	// --- sample side ---

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 88;
			IDLE_BOTH:   return $urandom_range(99) < 11;
			default:     return 1'b0;
		endcase
	endfunction

	// Offer one frame and hold it until transferred. Valid stays high after
	// the transfer; the next call either replaces the payload or drops valid
	// at the following falling edge.
	task automatic send_frame(logic cmd, accel_t z, accel_t f, accel_t s,
			logic typed, fall_t want);
		fall_t predicted;
		@(negedge clk);
		while (sender_gap()) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid         = 1'b1;
		sample_ch.command       = cmd;
		sample_ch.accel_z       = z;
		sample_ch.accel_forward = f;
		sample_ch.accel_side    = s;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		predicted = predict_fall(cmd, z, f, s);
		expected_falls.push_back(typed ? want : predicted);
		frames_sent++;
	endtask

	// Drop valid and wait until every queued result has come back.
	task automatic settle();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (expected_falls.size() != 0)
			@(posedge clk);
	endtask

	// --- configuration ---

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BACK_THRESHOLD:  cfg_shadow.back_threshold  = data[ACCEL_W-1:0];
			REG_FRONT_THRESHOLD: cfg_shadow.front_threshold = data[ACCEL_W-1:0];
			REG_RIGHT_THRESHOLD: cfg_shadow.right_threshold = data[ACCEL_W-1:0];
			REG_LEFT_THRESHOLD:  cfg_shadow.left_threshold  = data[ACCEL_W-1:0];
			REG_REAR_THRESHOLD:  cfg_shadow.rear_threshold  = data[ACCEL_W-1:0];
			REG_UPRIGHT_Z_LIMIT: cfg_shadow.upright_z_limit = data[ACCEL_W-1:0];
			REG_CONFIRM_COUNT:   cfg_shadow.confirm_count   = data[CONFIRM_W-1:0];
			default: ;  // unmapped index, ignored by the block
		endcase
	endtask

	// Upper data bits on the confirm write are junk the block must ignore.
	task automatic program_cfg(accel_t back, accel_t front, accel_t right, accel_t left,
			accel_t rear, accel_t upright, logic [CONFIRM_W-1:0] confirm);
		logic [CFG_DATA_W-1:0] confirm_word;
		confirm_word                  = CFG_DATA_W'($urandom);
		confirm_word[CONFIRM_W-1:0]   = confirm;
		write_reg(REG_BACK_THRESHOLD, back);
		write_reg(REG_FRONT_THRESHOLD, front);
		write_reg(REG_RIGHT_THRESHOLD, right);
		write_reg(REG_LEFT_THRESHOLD, left);
		write_reg(REG_REAR_THRESHOLD, rear);
		write_reg(REG_UPRIGHT_Z_LIMIT, upright);
		write_reg(REG_CONFIRM_COUNT, confirm_word);
	endtask

	// Mostly near the reset value so the directions stay reachable.
	function automatic accel_t random_threshold(accel_t base);
		if ($urandom_range(3) == 0)
			return accel_t'($urandom);
		return accel_t'(wide(base) + longint'($urandom_range(8388608)) - 4194304);
	endfunction

	task automatic program_random_cfg();
		logic [CONFIRM_W-1:0] confirm;
		confirm = CONFIRM_W'(($urandom_range(3) == 0) ? $urandom_range(255)
			: $urandom_range(8));
		program_cfg(random_threshold(RST_BACK_THRESHOLD),
			random_threshold(RST_FRONT_THRESHOLD),
			random_threshold(RST_RIGHT_THRESHOLD),
			random_threshold(RST_LEFT_THRESHOLD),
			random_threshold(RST_REAR_THRESHOLD),
			random_threshold(RST_UPRIGHT_Z_LIMIT), confirm);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
	endtask

	// --- random stimulus ---

	// Field value biased toward the two thresholds on that axis and the extremes.
	function automatic accel_t pick_axis(accel_t lo_edge, accel_t hi_edge);
		int jitter;
		jitter = int'($urandom_range(8)) - 4;
		case ($urandom_range(7))
			0, 1:    return accel_t'($urandom);
			2:       return ACC_MAX;
			3:       return ACC_MIN;
			4:       return accel_t'(wide(lo_edge) + jitter);
			5:       return accel_t'(wide(hi_edge) + jitter);
			6:       return accel_t'(int'($urandom_range(2097152)) - 1048576);
			default: return accel_t'(int'($urandom_range(2)) - 1);
		endcase
	endfunction

	// Most traffic repeats one frame so a run builds up; some runs are broken
	// by a clear, and some frames are plain noise.
	task automatic random_phase(int count);
		int     goal;
		int     span;
		int     cut;
		accel_t z;
		accel_t f;
		accel_t s;
		goal = frames_sent + count;
		while (frames_sent < goal) begin
			if ($urandom_range(9) == 0) begin
				send_frame(logic'($urandom_range(1)), accel_t'($urandom),
					accel_t'($urandom), accel_t'($urandom), PREDICTED, FALL_NONE);
			end else begin
				z    = pick_axis(cfg_shadow.upright_z_limit, cfg_shadow.back_threshold);
				f    = pick_axis(cfg_shadow.rear_threshold, cfg_shadow.front_threshold);
				s    = pick_axis(cfg_shadow.left_threshold, cfg_shadow.right_threshold);
				span = cfg_shadow.confirm_count + 4;
				if (span > 24)
					span = 24;
				span = $urandom_range(1, span);
				cut  = ($urandom_range(3) == 0) ? int'($urandom_range(span - 1)) : -1;
				for (int k = 0; k < span; k++) begin
					if (k == cut)
						send_frame(CMD_CLEAR, accel_t'($urandom), accel_t'($urandom),
							accel_t'($urandom), TYPED, FALL_NONE);
					else
						send_frame(CMD_SAMPLE, z, f, s, PREDICTED, FALL_NONE);
				end
			end
		end
	endtask

	// --- result side ---

	// Ready is redrawn every falling edge; a hold-off request pins it low for
	// a long stretch so the pipeline fills and backs up into the sample side.
	initial begin
		result_ch.ready = 1'b0;
		hold_left       = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				case (idle_mode)
					IDLE_RECEIVER: result_ch.ready = $urandom_range(99) >= 88;
					IDLE_BOTH:     result_ch.ready = $urandom_range(99) >= 11;
					default:       result_ch.ready = 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		fall_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_falls.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, fall_state=%0d",
					result_ch.fall_state));
			end else begin
				want = expected_falls.pop_front();
				if (result_ch.fall_state !== want)
					report_mismatch($sformatf("fall_state got %0d want %0d",
						result_ch.fall_state, want));
			end
		end
	end

	// Watchdog: a long stretch with no transfer on either side means a hang.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// --- main sequence ---

	initial begin
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_BACK_THRESHOLD;
		cfg_data                = '0;
		sample_ch.valid         = 1'b0;
		sample_ch.command       = CMD_SAMPLE;
		sample_ch.accel_z       = '0;
		sample_ch.accel_forward = '0;
		sample_ch.accel_side    = '0;
		idle_mode               = IDLE_NONE;
		hold_req                = 1'b0;
		frames_sent             = 0;
		mismatches              = 0;
		quiet_cycles            = 0;
		cfg_shadow = '{RST_BACK_THRESHOLD, RST_FRONT_THRESHOLD, RST_RIGHT_THRESHOLD,
			RST_LEFT_THRESHOLD, RST_REAR_THRESHOLD, RST_UPRIGHT_Z_LIMIT, RST_CONFIRM_COUNT};
		foreach (run_len[i])
			run_len[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under reset configuration, no idling
		foreach (directed_rows[i])
			send_frame(directed_rows[i].cmd, directed_rows[i].z, directed_rows[i].f,
				directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

		// Random phases. Idle mode cycles through none / sender / receiver / both.
		// Registers only change once the pipeline has drained.
		for (int p = 0; p < 8; p++) begin
			settle();
			idle_mode = idle_mode_t'(p % 4);
			case (p)
				1: program_cfg(ACC_MAX, ACC_MAX, ACC_MAX, ACC_MAX, ACC_MAX, ACC_MAX, 8'd0);
				2: program_cfg(ACC_MIN, ACC_MIN, ACC_MIN, ACC_MIN, ACC_MIN, ACC_MIN, 8'd0);
				// saturation: run reaches its max of 255, which beats 254 ...
				4: program_cfg(RST_BACK_THRESHOLD, RST_FRONT_THRESHOLD, RST_RIGHT_THRESHOLD,
					RST_LEFT_THRESHOLD, RST_REAR_THRESHOLD, RST_UPRIGHT_Z_LIMIT, 8'd254);
				// ... but never beats 255, so nothing is confirmed
				5: write_reg(REG_CONFIRM_COUNT, {18'h3FFFF, 8'd255});
				default: program_random_cfg();
			endcase
			if (p == 0)
				hold_req = 1'b1;  // back-pressure the whole pipeline early on
			if (p == 4 || p == 5) begin
				// upside down, forward dominant and negative: a rear run
				repeat (SAT_RUN)
					send_frame(CMD_SAMPLE, 26'sd1, ACC_MIN, '0, PREDICTED, FALL_NONE);
				random_phase(120);
			end else begin
				random_phase(PHASE_ITEMS);
			end
		end

		settle();
		repeat (4) @(posedge clk);  // anything arriving now is unexpected
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
